/* hw/rtl/ylkv_pkg.sv */
// package of types and constants for the yaml line key/value lexer
package ylkv_pkg;

  localparam int unsigned LineCapacity = 256;
  localparam int unsigned AddrW = $clog2(LineCapacity);
  localparam int unsigned FillW = AddrW + 1;

  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChFf    = 8'h0c;
  localparam logic [7:0] ChUnder = 8'h5f;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChDq    = 8'h22;
  localparam logic [7:0] ChSq    = 8'h27;
  localparam logic [7:0] ChSpace = 8'h20;

  typedef enum logic [1:0] {
    KindToken = 2'd0,
    KindEnd   = 2'd1,
    KindError = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ErrNone     = 3'd0,
    ErrTab      = 3'd1,
    ErrQuote    = 3'd2,
    ErrColon    = 3'd3,
    ErrChar     = 3'd4,
    ErrTooLong  = 3'd5
  } err_e;

  // sequencer states of the lexer
  typedef enum logic [4:0] {
    StIdle, StByte, StLine, StCrRd, StCrChk, StIndRd, StIndChk,
    StCmRd, StCmChk, StTrRd, StTrChk, StKeyRd, StKeyChk,
    StQkRd, StQkChk, StWsRd, StWsChk, StKtRd, StKtChk,
    StVwRd, StVwChk, StQvRd, StQvChk, StEmit, StEndChk, StOut
  } lexer_state_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        end_of_input;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] line_offset;
    logic [7:0]  indent;
    logic [7:0]  key_start;
    logic [7:0]  key_length;
    logic [7:0]  value_start;
    logic [7:0]  value_length;
    logic [2:0]  error_code;
    logic [15:0] line_number;
    logic        last_result;
  } out_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c == ChSpace || c == ChTab || c == ChFf || c == ChCr;
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39) || c == ChUnder;
  endfunction

  function automatic logic is_quote(input logic [7:0] c);
    return c == ChDq || c == ChSq;
  endfunction

  function automatic logic [7:0] sat8(input logic [FillW-1:0] v);
    logic [7:0] r;
    if (v > FillW'(255)) r = 8'hff;
    else r = v[7:0];
    return r;
  endfunction

endpackage

/* hw/rtl/ylkv_if.sv */
// valid/ready channel interfaces for the lexer
interface ylkv_in_if;
  logic           valid;
  logic           ready;
  ylkv_pkg::in_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ylkv_out_if;
  logic           valid;
  logic           ready;
  ylkv_pkg::out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/yaml_line_key_value_lexer.sv */
// yaml line key/value lexer: line buffer, rescanning sequencer and result register
// a plain byte is captured in StIdle and written to the buffer in StByte; a newline or end rescans
// the line through the single buffer read port
// one transaction at a time; ready is low while a line is scanned or its result, or the
// end result, waits for the output register
// reset: asynchronous; counters, fill, flags and sequencer clear, buffer contents do not
module yaml_line_key_value_lexer (
  input logic         clk_i,
  input logic         rst_ni,
  ylkv_in_if.sink     in_if,
  ylkv_out_if.source  out_if
);

  localparam int unsigned AW = ylkv_pkg::AddrW;
  localparam int unsigned FW = ylkv_pkg::FillW;

  // sub-phase codes for the generic whitespace skip
  typedef enum logic [1:0] {
    WsAfterQkey, WsValue
  } ws_e;

  logic [7:0] mem_q [ylkv_pkg::LineCapacity];
  logic [7:0] rd_q, prev_q;
  logic [AW-1:0] ra;
  logic re;

  ylkv_pkg::lexer_state_e st_q, st_d;
  logic [FW-1:0] fill_q, n_q, i_q, ind_q, end_q, p_q, ks_q, kl_q, vs_q, vl_q;
  logic [FW-1:0] n_d, i_d, ind_d, end_d, p_d, ks_d, kl_d, vs_d, vl_d, fill_d;
  logic [7:0] quote_q, quote_d, c0_q, c0_d;
  logic ovf_q, ovf_d, alarm_q, alarm_d, eoi_q, eoi_d, lfend_q, lfend_d;
  ws_e ws_q, ws_d;
  logic [15:0] lc_q, lc_d;
  logic [31:0] pos_q, pos_d, off_q, off_d;
  ylkv_pkg::in_t in_q, in_d;
  ylkv_pkg::out_t o_q, o_d, r_q, r_d;
  logic ov_q, ov_d;
  logic we;

  // line buffer
  always_ff @(posedge clk_i) begin
    if (we) mem_q[fill_q[AW-1:0]] <= in_q.data_byte;
    if (re) rd_q <= mem_q[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ylkv_pkg::StIdle; fill_q <= '0; ovf_q <= 1'b0; alarm_q <= 1'b0;
      lc_q <= '0; pos_q <= '0; off_q <= '0; ov_q <= 1'b0; eoi_q <= 1'b0;
      lfend_q <= 1'b0;
    end else begin
      st_q <= st_d; fill_q <= fill_d; ovf_q <= ovf_d; alarm_q <= alarm_d;
      lc_q <= lc_d; pos_q <= pos_d; off_q <= off_d; ov_q <= ov_d; eoi_q <= eoi_d;
      lfend_q <= lfend_d;
    end
  end

  // scan registers and the staged line result
  always_ff @(posedge clk_i) begin
    n_q <= n_d; i_q <= i_d; ind_q <= ind_d; end_q <= end_d; p_q <= p_d;
    ks_q <= ks_d; kl_q <= kl_d; vs_q <= vs_d; vl_q <= vl_d; quote_q <= quote_d;
    c0_q <= c0_d; in_q <= in_d; o_q <= o_d; r_q <= r_d; ws_q <= ws_d;
    if (re) prev_q <= rd_q;
  end

  assign in_if.ready = (st_q == ylkv_pkg::StIdle);
  assign out_if.valid = ov_q;
  assign out_if.payload = o_q;

  // next state
  always_comb begin
    st_d = st_q; n_d = n_q; i_d = i_q; ind_d = ind_q; end_d = end_q; p_d = p_q;
    ks_d = ks_q; kl_d = kl_q; vs_d = vs_q; vl_d = vl_q; quote_d = quote_q;
    c0_d = c0_q; in_d = in_q; o_d = o_q; r_d = r_q; ws_d = ws_q;
    fill_d = fill_q; ovf_d = ovf_q; alarm_d = alarm_q; lc_d = lc_q;
    pos_d = pos_q; off_d = off_q; ov_d = ov_q; eoi_d = eoi_q; lfend_d = lfend_q;
    we = 1'b0; re = 1'b0; ra = '0;
    if (ov_q && out_if.ready) ov_d = 1'b0;
    case (st_q)
      ylkv_pkg::StIdle: begin
        if (in_if.valid) begin
          in_d = in_if.payload;
          if (!alarm_q) st_d = ylkv_pkg::StByte;
        end
      end
      ylkv_pkg::StByte: begin
        eoi_d = in_q.end_of_input;
        lfend_d = 1'b0;
        if (in_q.has_byte) begin
          pos_d = pos_q + 32'd1;
          if (in_q.data_byte == ylkv_pkg::ChLf) begin
            lfend_d = 1'b1;
            st_d = ylkv_pkg::StLine;
          end else begin
            if (fill_q < FW'(ylkv_pkg::LineCapacity)) begin
              we = 1'b1; fill_d = fill_q + FW'(1);
            end else ovf_d = 1'b1;
            st_d = ylkv_pkg::StEndChk;
          end
        end else st_d = ylkv_pkg::StEndChk;
      end
      ylkv_pkg::StEndChk: begin
        if (!eoi_q) st_d = ylkv_pkg::StIdle;
        else if (fill_q != '0 || ovf_q) begin
          lfend_d = 1'b0; st_d = ylkv_pkg::StLine;
        end else if (!ov_q) begin
          o_d = '0;
          o_d.kind = ylkv_pkg::KindEnd;
          o_d.line_offset = pos_q;
          o_d.line_number = (lc_q != 16'hffff) ? lc_q + 16'd1 : 16'hffff;
          o_d.last_result = 1'b1;
          ov_d = 1'b1;
          lc_d = '0; pos_d = '0; off_d = '0; eoi_d = 1'b0;
          st_d = ylkv_pkg::StIdle;
        end
      end
      ylkv_pkg::StLine: begin
        if (lc_q != 16'hffff) lc_d = lc_q + 16'd1;
        n_d = fill_q;
        if (ovf_q) begin
          r_d = '0; r_d.error_code = ylkv_pkg::ErrTooLong; st_d = ylkv_pkg::StEmit;
          r_d.kind = ylkv_pkg::KindError;
        end else if (fill_q == '0) st_d = ylkv_pkg::StOut;
        else begin
          re = 1'b1; ra = AW'(fill_q - FW'(1)); st_d = ylkv_pkg::StCrRd;
        end
      end
      ylkv_pkg::StCrRd: st_d = ylkv_pkg::StCrChk;
      ylkv_pkg::StCrChk: begin
        if (rd_q == ylkv_pkg::ChCr) n_d = n_q - FW'(1);
        ind_d = '0; st_d = ylkv_pkg::StIndRd;
        if (rd_q == ylkv_pkg::ChCr && n_q == FW'(1)) st_d = ylkv_pkg::StOut;
        re = 1'b1; ra = '0;
      end
      ylkv_pkg::StIndRd: st_d = ylkv_pkg::StIndChk;
      ylkv_pkg::StIndChk: begin
        if (ind_q == n_q) st_d = ylkv_pkg::StOut;
        else if (rd_q == ylkv_pkg::ChSpace) begin
          ind_d = ind_q + FW'(1); re = 1'b1; ra = AW'(ind_q + FW'(1));
          st_d = ylkv_pkg::StIndRd;
        end else if (rd_q == ylkv_pkg::ChTab) begin
          r_d = '0; r_d.kind = ylkv_pkg::KindError;
          r_d.error_code = ylkv_pkg::ErrTab; st_d = ylkv_pkg::StEmit;
        end else begin
          c0_d = rd_q; i_d = ind_q; end_d = n_q; quote_d = '0;
          re = 1'b1; ra = AW'(ind_q); st_d = ylkv_pkg::StCmRd;
        end
      end
      // comment search; prev_q holds the byte before i
      ylkv_pkg::StCmRd: st_d = ylkv_pkg::StCmChk;
      ylkv_pkg::StCmChk: begin
        if (quote_q != '0) begin
          if (rd_q == quote_q) quote_d = '0;
        end else if (ylkv_pkg::is_quote(rd_q)) quote_d = rd_q;
        else if (rd_q == ylkv_pkg::ChHash &&
                 (i_q == ind_q || ylkv_pkg::is_ws(prev_q))) begin
          end_d = i_q;
        end
        if (quote_q == '0 && !ylkv_pkg::is_quote(rd_q) && rd_q == ylkv_pkg::ChHash &&
            (i_q == ind_q || ylkv_pkg::is_ws(prev_q))) begin
          st_d = ylkv_pkg::StTrChk;
          if (i_q != ind_q) begin
            re = 1'b1; ra = AW'(i_q - FW'(1)); st_d = ylkv_pkg::StTrRd;
          end
        end else if (i_q + FW'(1) == n_q) begin
          end_d = n_q;
          // skip trim when no comment
          i_d = n_q;
          st_d = ylkv_pkg::StKeyRd; re = 1'b1; ra = AW'(ind_q);
        end else begin
          i_d = i_q + FW'(1); re = 1'b1; ra = AW'(i_q + FW'(1));
          st_d = ylkv_pkg::StCmRd;
        end
      end
      ylkv_pkg::StTrRd: st_d = ylkv_pkg::StTrChk;
      ylkv_pkg::StTrChk: begin
        if (end_q != ind_q && ylkv_pkg::is_ws(rd_q)) begin
          end_d = end_q - FW'(1);
          if (end_q - FW'(1) != ind_q) begin
            re = 1'b1; ra = AW'(end_q - FW'(2)); st_d = ylkv_pkg::StTrRd;
          end else st_d = ylkv_pkg::StOut;
        end else if (end_q == ind_q) st_d = ylkv_pkg::StOut;
        else begin
          re = 1'b1; ra = AW'(ind_q); st_d = ylkv_pkg::StKeyRd;
        end
      end
      ylkv_pkg::StKeyRd: st_d = ylkv_pkg::StKeyChk;
      ylkv_pkg::StKeyChk: begin
        p_d = ind_q;
        if (ylkv_pkg::is_quote(c0_q)) begin
          ks_d = ind_q + FW'(1); p_d = ind_q + FW'(1);
          if (ind_q + FW'(1) == end_q) begin
            r_d = '0; r_d.kind = ylkv_pkg::KindError;
            r_d.error_code = ylkv_pkg::ErrQuote; st_d = ylkv_pkg::StEmit;
          end else begin
            re = 1'b1; ra = AW'(ind_q + FW'(1)); st_d = ylkv_pkg::StQkRd;
          end
        end else if (!ylkv_pkg::is_ident(c0_q)) begin
          r_d = '0; r_d.kind = ylkv_pkg::KindError;
          r_d.error_code = ylkv_pkg::ErrChar; st_d = ylkv_pkg::StEmit;
        end else begin
          ks_d = ind_q; re = 1'b1; ra = AW'(ind_q); st_d = ylkv_pkg::StKtRd;
        end
      end
      // quoted key close search
      ylkv_pkg::StQkRd: st_d = ylkv_pkg::StQkChk;
      ylkv_pkg::StQkChk: begin
        if (rd_q == c0_q) begin
          kl_d = p_q - ks_q; p_d = p_q + FW'(1); ws_d = WsAfterQkey;
          if (p_q + FW'(1) == end_q) begin
            r_d = '0; r_d.kind = ylkv_pkg::KindError;
            r_d.error_code = ylkv_pkg::ErrColon; st_d = ylkv_pkg::StEmit;
          end else begin
            re = 1'b1; ra = AW'(p_q + FW'(1)); st_d = ylkv_pkg::StWsRd;
          end
        end else if (p_q + FW'(1) == end_q) begin
          r_d = '0; r_d.kind = ylkv_pkg::KindError;
          r_d.error_code = ylkv_pkg::ErrQuote; st_d = ylkv_pkg::StEmit;
        end else begin
          p_d = p_q + FW'(1); re = 1'b1; ra = AW'(p_q + FW'(1));
          st_d = ylkv_pkg::StQkRd;
        end
      end
      // bare key: find colon
      ylkv_pkg::StKtRd: st_d = ylkv_pkg::StKtChk;
      ylkv_pkg::StKtChk: begin
        if (rd_q == ylkv_pkg::ChColon) begin
          kl_d = p_q - ks_q; i_d = p_q;
          if (p_q != ks_q) begin
            re = 1'b1; ra = AW'(p_q - FW'(1)); st_d = ylkv_pkg::StVwRd;
          end else begin
            p_d = p_q + FW'(1); ws_d = WsValue; st_d = ylkv_pkg::StWsChk;
            if (p_q + FW'(1) != end_q) begin
              re = 1'b1; ra = AW'(p_q + FW'(1)); st_d = ylkv_pkg::StWsRd;
            end
          end
        end else if (p_q + FW'(1) == end_q) begin
          r_d = '0; r_d.kind = ylkv_pkg::KindError;
          r_d.error_code = ylkv_pkg::ErrColon; st_d = ylkv_pkg::StEmit;
        end else begin
          p_d = p_q + FW'(1); re = 1'b1; ra = AW'(p_q + FW'(1));
          st_d = ylkv_pkg::StKtRd;
        end
      end
      // trim key tail; i holds colon position
      ylkv_pkg::StVwRd: st_d = ylkv_pkg::StVwChk;
      ylkv_pkg::StVwChk: begin
        if (ylkv_pkg::is_ws(rd_q) && kl_q != '0) begin
          kl_d = kl_q - FW'(1);
          if (kl_q != FW'(1)) begin
            re = 1'b1; ra = AW'(ks_q + kl_q - FW'(2)); st_d = ylkv_pkg::StVwRd;
          end
        end
        if (!(ylkv_pkg::is_ws(rd_q) && kl_q != '0 && kl_q != FW'(1))) begin
          p_d = i_q + FW'(1); ws_d = WsValue; st_d = ylkv_pkg::StWsChk;
          if (i_q + FW'(1) != end_q) begin
            re = 1'b1; ra = AW'(i_q + FW'(1)); st_d = ylkv_pkg::StWsRd;
          end
        end
      end
      // whitespace skip; StWsChk entered without read means p == end
      ylkv_pkg::StWsRd: st_d = ylkv_pkg::StWsChk;
      ylkv_pkg::StWsChk: begin
        if (p_q != end_q && ylkv_pkg::is_ws(rd_q)) begin
          p_d = p_q + FW'(1);
          if (p_q + FW'(1) != end_q) begin
            re = 1'b1; ra = AW'(p_q + FW'(1)); st_d = ylkv_pkg::StWsRd;
          end
        end else if (ws_q == WsAfterQkey) begin
          if (p_q == end_q || rd_q != ylkv_pkg::ChColon) begin
            r_d = '0; r_d.kind = ylkv_pkg::KindError;
            r_d.error_code = ylkv_pkg::ErrColon; st_d = ylkv_pkg::StEmit;
          end else begin
            p_d = p_q + FW'(1); ws_d = WsValue; st_d = ylkv_pkg::StWsChk;
            if (p_q + FW'(1) != end_q) begin
              re = 1'b1; ra = AW'(p_q + FW'(1)); st_d = ylkv_pkg::StWsRd;
            end
          end
        end else begin
          vs_d = '0; vl_d = '0;
          r_d = '0; r_d.kind = ylkv_pkg::KindToken; st_d = ylkv_pkg::StEmit;
          if (p_q != end_q) begin
            if (ylkv_pkg::is_quote(rd_q)) begin
              c0_d = rd_q; vs_d = p_q + FW'(1); p_d = p_q + FW'(1);
              if (p_q + FW'(1) == end_q) r_d.error_code = ylkv_pkg::ErrQuote;
              else begin
                re = 1'b1; ra = AW'(p_q + FW'(1)); st_d = ylkv_pkg::StQvRd;
              end
            end else begin
              vs_d = p_q; vl_d = end_q - p_q;
            end
          end
          if (ylkv_pkg::is_quote(rd_q) && p_q != end_q && p_q + FW'(1) == end_q)
            r_d.kind = ylkv_pkg::KindError;
        end
      end
      ylkv_pkg::StQvRd: st_d = ylkv_pkg::StQvChk;
      ylkv_pkg::StQvChk: begin
        if (rd_q == c0_q) begin
          vl_d = p_q - vs_q; r_d = '0; r_d.kind = ylkv_pkg::KindToken;
          st_d = ylkv_pkg::StEmit;
        end else if (p_q + FW'(1) == end_q) begin
          r_d = '0; r_d.kind = ylkv_pkg::KindError;
          r_d.error_code = ylkv_pkg::ErrQuote; st_d = ylkv_pkg::StEmit;
        end else begin
          p_d = p_q + FW'(1); re = 1'b1; ra = AW'(p_q + FW'(1));
          st_d = ylkv_pkg::StQvRd;
        end
      end
      // present the line result once the output register is free
      ylkv_pkg::StEmit: begin
        if (!ov_q) begin
          o_d = r_q;
          o_d.line_offset = off_q;
          o_d.line_number = lc_q;
          if (r_q.kind == ylkv_pkg::KindToken) begin
            o_d.indent = ylkv_pkg::sat8(ind_q);
            o_d.key_start = ylkv_pkg::sat8(ks_q);
            o_d.key_length = ylkv_pkg::sat8(kl_q);
            o_d.value_start = ylkv_pkg::sat8(vs_q);
            o_d.value_length = ylkv_pkg::sat8(vl_q);
            o_d.last_result = !eoi_q;
          end else begin
            alarm_d = 1'b1; o_d.last_result = 1'b1;
          end
          ov_d = 1'b1;
          st_d = ylkv_pkg::StOut;
        end
      end
      // line done: reset buffer fill and, unless an error alarm is set, continue with end handling at end of input
      ylkv_pkg::StOut: begin
        fill_d = '0; ovf_d = 1'b0;
        if (lfend_q) off_d = pos_q;
        if (alarm_d || alarm_q) st_d = ylkv_pkg::StIdle;
        else if (eoi_q) begin
          fill_d = '0; st_d = ylkv_pkg::StEndChk;
        end else st_d = ylkv_pkg::StIdle;
      end
      default: st_d = ylkv_pkg::StIdle;
    endcase
  end

endmodule
